FILE: src/protobuf_wire_field_parser_macros.svh
// assertion macros for the protobuf wire field parser
// expects aclk and aresetn in the scope where a macro is used
`ifndef PROTOBUF_WIRE_FIELD_PARSER_MACROS_SVH
`define PROTOBUF_WIRE_FIELD_PARSER_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define PBWF_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define PBWF_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pbwf_pkg.sv
// shared types and codes for the protobuf wire field parser
// no dependencies; used by pbwf_widen, pbwf_core and the top level
`default_nettype none

package pbwf_pkg;

    // field widths of one transaction
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned FIELD_W = 61;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned CNT_W   = 4;

    // stream widths
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 144;
    localparam int unsigned M_TUSER_W = 3;

    // varint limits
    localparam logic [CNT_W-1:0] VARINT_MAX_BYTES = 4'd10;
    localparam logic [CNT_W-1:0] FIX64_BYTES      = 4'd8;
    localparam logic [CNT_W-1:0] FIX32_BYTES      = 4'd4;

    // wire type codes
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_SGROUP = 3'd3;
    localparam logic [2:0] WT_EGROUP = 3'd4;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    // decoder phase
    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VARINT  = 3'd1,
        PH_FIX64   = 3'd2,
        PH_LENVAR  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_FIX32   = 3'd5
    } phase_t;

    // result kind
    typedef enum logic [2:0] {
        KIND_SCALAR  = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_PAYLOAD = 3'd2,
        KIND_END     = 3'd3,
        KIND_ERROR   = 3'd4
    } kind_t;

    // error cause
    typedef enum logic [2:0] {
        CAUSE_NONE      = 3'd0,
        CAUSE_ZERO      = 3'd1,
        CAUSE_GROUP     = 3'd2,
        CAUSE_UNKNOWN   = 3'd3,
        CAUSE_OVERLONG  = 3'd4,
        CAUSE_TRUNCATED = 3'd5
    } cause_t;

    // one result transaction
    typedef struct packed {
        kind_t                kind;
        logic [FIELD_W-1:0]   field_id;
        logic [2:0]           wtype;
        logic [VALUE_W-1:0]   value;
        logic [BYTE_W-1:0]    payload_byte;
        logic                 message_end;
        cause_t               error_cause;
    } result_t;

endpackage

`default_nettype wire

FILE: src/pbwf_widen.sv
// widens single-precision bits to double-precision bits
// subnormals normalized, infinities kept, nans quieted; uses pbwf_pkg
`default_nettype none

module pbwf_widen (
    input  wire logic [31:0]                   sp_bits,
    output logic      [pbwf_pkg::VALUE_W-1:0]  dp_bits
);

    logic        sign;
    logic [7:0]  sp_exp;
    logic [22:0] sp_man;
    logic [4:0]  top_bit;
    logic [23:0] norm;
    logic [10:0] dp_exp;
    logic [22:0] dp_frac;

    assign sign   = sp_bits[31];
    assign sp_exp = sp_bits[30:23];
    assign sp_man = sp_bits[22:0];

    // position of the highest set mantissa bit, for subnormals
    always_comb begin
        top_bit = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (sp_man[i]) begin
                top_bit = 5'(i);
            end
        end
    end

    assign norm = {1'b0, sp_man} << (5'd23 - top_bit);

    // exponent rebias and special cases
    always_comb begin
        dp_exp  = {3'b000, sp_exp} + 11'd896;
        dp_frac = sp_man;
        dp_bits = {sign, dp_exp, dp_frac, 29'd0};
        if (sp_exp == 8'h00) begin
            if (sp_man == 23'd0) begin
                dp_bits = {sign, 63'd0};
            end else begin
                dp_exp  = {6'd0, top_bit} + 11'd874;
                dp_frac = norm[22:0];
                dp_bits = {sign, dp_exp, dp_frac, 29'd0};
            end
        end else if (sp_exp == 8'hFF) begin
            if (sp_man == 23'd0) begin
                dp_bits = {sign, 11'h7FF, 52'd0};
            end else begin
                // payload keeps its place, quiet bit forced on top of it
                dp_bits = {sign, 11'h7FF, sp_man | 23'h400000, 29'd0};
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/pbwf_core.sv
// field decoding state machine: tag, varint, fixed and payload handling
// uses pbwf_pkg and pbwf_widen
`default_nettype none

module pbwf_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          item_valid,
    input  wire logic [pbwf_pkg::BYTE_W-1:0]   item_byte,
    input  wire logic                          item_last,
    output logic                               res_valid,
    output pbwf_pkg::result_t                  res
);

    // decoder state
    pbwf_pkg::phase_t                  phase_reg, phase_next;
    logic [pbwf_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                              err_reg, err_next;
    logic [pbwf_pkg::VALUE_W-1:0]      acc_reg, acc_next;
    logic [pbwf_pkg::FIELD_W-1:0]      field_reg, field_next;
    logic [2:0]                        type_reg, type_next;
    logic [pbwf_pkg::VALUE_W-1:0]      remain_reg, remain_next;

    // per-byte step values
    logic                              tag_fresh;
    logic [pbwf_pkg::VALUE_W-1:0]      acc_base;
    logic [pbwf_pkg::FIELD_W-1:0]      field_base;
    logic [2:0]                        type_base;
    logic [pbwf_pkg::CNT_W-1:0]        cnt_inc;
    logic [6:0]                        v_shift;
    logic [pbwf_pkg::VALUE_W-1:0]      v_acc;
    logic                              v_done;
    logic                              v_over;
    logic [pbwf_pkg::VALUE_W-1:0]      f_acc;
    logic                              f_done;
    logic [pbwf_pkg::VALUE_W-1:0]      widened;

    // decoded step before end-of-message handling
    pbwf_pkg::cause_t                  cause;
    logic                              have;
    pbwf_pkg::kind_t                   kind;
    logic [pbwf_pkg::VALUE_W-1:0]      value;
    logic [pbwf_pkg::BYTE_W-1:0]       pbyte;
    pbwf_pkg::phase_t                  phase_d;
    logic [pbwf_pkg::CNT_W-1:0]        cnt_d;
    logic [pbwf_pkg::VALUE_W-1:0]      acc_d;
    logic [pbwf_pkg::FIELD_W-1:0]      field_d;
    logic [2:0]                        type_d;
    logic [pbwf_pkg::VALUE_W-1:0]      remain_d;

    // a fresh tag starts from a clean field context
    assign tag_fresh  = (phase_reg == pbwf_pkg::PH_TAG) && (cnt_reg == '0);
    assign acc_base   = tag_fresh ? '0 : acc_reg;
    assign field_base = tag_fresh ? '0 : field_reg;
    assign type_base  = tag_fresh ? 3'd0 : type_reg;
    assign cnt_inc    = cnt_reg + 4'd1;

    // varint byte: seven bits at 7*count, nothing past the tenth byte
    assign v_shift = {3'b000, cnt_reg} * 7'd7;
    assign v_acc   = (cnt_reg < pbwf_pkg::VARINT_MAX_BYTES)
                   ? (acc_base | ({57'd0, item_byte[6:0]} << v_shift))
                   : acc_base;
    assign v_done  = !item_byte[7];
    assign v_over  = item_byte[7] && (cnt_inc >= pbwf_pkg::VARINT_MAX_BYTES);

    // fixed byte: little-endian placement
    assign f_acc  = acc_base | ({56'd0, item_byte} << {cnt_reg[2:0], 3'b000});
    assign f_done = (phase_reg == pbwf_pkg::PH_FIX64) ? (cnt_inc >= pbwf_pkg::FIX64_BYTES)
                                                       : (cnt_inc >= pbwf_pkg::FIX32_BYTES);

    pbwf_widen u_widen (
        .sp_bits (f_acc[31:0]),
        .dp_bits (widened)
    );

    // per-phase decode of the current byte
    always_comb begin
        cause    = pbwf_pkg::CAUSE_NONE;
        have     = 1'b0;
        kind     = pbwf_pkg::KIND_SCALAR;
        value    = '0;
        pbyte    = '0;
        phase_d  = phase_reg;
        cnt_d    = cnt_reg;
        acc_d    = acc_base;
        field_d  = field_base;
        type_d   = type_base;
        remain_d = remain_reg;
        case (phase_reg)
            pbwf_pkg::PH_TAG: begin
                acc_d = v_acc;
                cnt_d = cnt_inc;
                if (v_over) begin
                    cause = pbwf_pkg::CAUSE_OVERLONG;
                end else if (v_done) begin
                    acc_d   = '0;
                    cnt_d   = '0;
                    field_d = v_acc[63:3];
                    type_d  = v_acc[2:0];
                    if (v_acc[63:3] == '0) begin
                        cause = pbwf_pkg::CAUSE_ZERO;
                    end else begin
                        case (v_acc[2:0])
                            pbwf_pkg::WT_VARINT: phase_d = pbwf_pkg::PH_VARINT;
                            pbwf_pkg::WT_FIX64:  phase_d = pbwf_pkg::PH_FIX64;
                            pbwf_pkg::WT_LEN:    phase_d = pbwf_pkg::PH_LENVAR;
                            pbwf_pkg::WT_FIX32:  phase_d = pbwf_pkg::PH_FIX32;
                            pbwf_pkg::WT_SGROUP,
                            pbwf_pkg::WT_EGROUP: cause = pbwf_pkg::CAUSE_GROUP;
                            default:             cause = pbwf_pkg::CAUSE_UNKNOWN;
                        endcase
                    end
                end
            end
            pbwf_pkg::PH_VARINT, pbwf_pkg::PH_LENVAR: begin
                acc_d = v_acc;
                cnt_d = cnt_inc;
                if (v_over) begin
                    cause = pbwf_pkg::CAUSE_OVERLONG;
                end else if (v_done) begin
                    acc_d = '0;
                    cnt_d = '0;
                    have  = 1'b1;
                    if (phase_reg == pbwf_pkg::PH_VARINT) begin
                        // zigzag decode
                        kind    = pbwf_pkg::KIND_SCALAR;
                        value   = (v_acc >> 1) ^ {pbwf_pkg::VALUE_W{v_acc[0]}};
                        phase_d = pbwf_pkg::PH_TAG;
                    end else begin
                        kind     = pbwf_pkg::KIND_HEADER;
                        value    = v_acc;
                        remain_d = v_acc;
                        phase_d  = (v_acc == '0) ? pbwf_pkg::PH_TAG : pbwf_pkg::PH_PAYLOAD;
                    end
                end
            end
            pbwf_pkg::PH_FIX64, pbwf_pkg::PH_FIX32: begin
                acc_d = f_acc;
                cnt_d = cnt_inc;
                if (f_done) begin
                    have    = 1'b1;
                    kind    = pbwf_pkg::KIND_SCALAR;
                    value   = (phase_reg == pbwf_pkg::PH_FIX64) ? f_acc : widened;
                    acc_d   = '0;
                    cnt_d   = '0;
                    phase_d = pbwf_pkg::PH_TAG;
                end
            end
            pbwf_pkg::PH_PAYLOAD: begin
                have  = 1'b1;
                kind  = pbwf_pkg::KIND_PAYLOAD;
                pbyte = item_byte;
                if (remain_reg != '0) begin
                    remain_d = remain_reg - 64'd1;
                end
                if (remain_d == '0) begin
                    phase_d = pbwf_pkg::PH_TAG;
                end
            end
            default: begin
                phase_d = phase_reg;
            end
        endcase

        // message ends inside a field
        if ((cause == pbwf_pkg::CAUSE_NONE) && item_last &&
            !((phase_d == pbwf_pkg::PH_TAG) && (cnt_d == '0))) begin
            cause = pbwf_pkg::CAUSE_TRUNCATED;
        end

        if (cause != pbwf_pkg::CAUSE_NONE) begin
            kind  = pbwf_pkg::KIND_ERROR;
            value = '0;
            pbyte = '0;
            have  = 1'b1;
        end
    end

    // next state: clear on message end, latch errors until then
    always_comb begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        err_next    = err_reg;
        acc_next    = acc_reg;
        field_next  = field_reg;
        type_next   = type_reg;
        remain_next = remain_reg;
        if (item_valid) begin
            if (!err_reg) begin
                phase_next  = phase_d;
                cnt_next    = cnt_d;
                acc_next    = acc_d;
                field_next  = field_d;
                type_next   = type_d;
                remain_next = remain_d;
                if ((cause != pbwf_pkg::CAUSE_NONE) && !item_last) begin
                    err_next = 1'b1;
                end
            end
            if (item_last) begin
                phase_next  = pbwf_pkg::PH_TAG;
                cnt_next    = '0;
                err_next    = 1'b0;
                acc_next    = '0;
                field_next  = '0;
                type_next   = 3'd0;
                remain_next = '0;
            end
        end
    end

    // result transaction
    always_comb begin
        res_valid        = item_valid && !err_reg && have;
        res.kind         = kind;
        res.field_id     = field_d;
        res.wtype        = type_d;
        res.value        = value;
        res.payload_byte = pbyte;
        res.message_end  = (cause == pbwf_pkg::CAUSE_NONE) && item_last;
        res.error_cause  = cause;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pbwf_pkg::PH_TAG;
            cnt_reg   <= '0;
            err_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            err_reg   <= err_next;
        end
    end

    // field context, no reset needed: a fresh tag ignores it
    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        field_reg  <= field_next;
        type_reg   <= type_next;
        remain_reg <= remain_next;
    end

endmodule

`default_nettype wire

FILE: src/protobuf_wire_field_parser.sv
// an accepted byte is held in the input register, then its result is loaded into the result register,
// which drives m_* until the result is taken
// throughput: one byte per cycle; the input register waits only while a held result is not taken
// bytes that give no result (tag, varint, fixed bytes mid-field) leave m_tvalid low
// reset: synchronous active-low aresetn empties both registers and returns the
// decoder to awaiting a tag with no latched error
`default_nettype none
`include "protobuf_wire_field_parser_macros.svh"

module protobuf_wire_field_parser (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [pbwf_pkg::S_TDATA_W-1:0]    s_tdata,   // [7:0] in_byte
    input  wire logic                              s_tlast,   // end_of_message
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [60:0] field id, [63:61] wire type, [127:64] value,
    // [135:128] payload_byte, [138:136] error_cause, [143:139] zero
    output logic      [pbwf_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic      [pbwf_pkg::M_TUSER_W-1:0]    m_tuser,   // [2:0] kind
    output logic                                   m_tlast    // message_end
);

    logic                              in_vld_reg, in_vld_next;
    logic [pbwf_pkg::BYTE_W-1:0]       in_byte_reg;
    logic                              in_last_reg;
    logic                              out_vld_reg, out_vld_next;
    pbwf_pkg::result_t                 out_reg;

    logic                              s_accept;
    logic                              advance;
    logic                              res_valid;
    pbwf_pkg::result_t                 res;

    logic                              out_is_err;
    logic                              out_has_cause;
    logic                              out_is_bytes;
    logic                              out_is_len;

    // the held byte moves on when the result register is free or draining
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // input register
    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_accept) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata[7:0];
            in_last_reg <= s_tlast;
        end
    end

    pbwf_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .item_byte  (in_byte_reg),
        .item_last  (in_last_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    // result register
    always_comb begin
        out_vld_next = out_vld_reg;
        if (advance && res_valid) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    // output packing
    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.message_end;
    assign m_tdata  = {5'd0, out_reg.error_cause, out_reg.payload_byte, out_reg.value,
                       out_reg.wtype, out_reg.field_id};

    // checks on the result register
    assign out_is_err    = out_vld_reg && (out_reg.kind == pbwf_pkg::KIND_ERROR);
    assign out_has_cause = out_vld_reg && (out_reg.error_cause != pbwf_pkg::CAUSE_NONE);
    assign out_is_bytes  = out_vld_reg && ((out_reg.kind == pbwf_pkg::KIND_HEADER) ||
                                           (out_reg.kind == pbwf_pkg::KIND_PAYLOAD));
    assign out_is_len    = (out_reg.wtype == pbwf_pkg::WT_LEN);

    `PBWF_CHECK(a_error_has_cause, out_is_err, out_has_cause, "error result without a cause")
    `PBWF_CHECK(a_cause_only_on_error, out_has_cause, out_is_err, "cause on a non-error result")
    `PBWF_CHECK(a_bytes_are_len_delim, out_is_bytes, out_is_len, "bytes outside a length field")
    `PBWF_CHECK(a_clean_end, out_vld_reg && out_reg.message_end, !out_is_err, "end on an error")

endmodule

`default_nettype wire
